[rtl/core/kfs_pkg.sv]
// kfs_pkg: shared types and constants of the keyframe animation sequencer
// no dependencies; used by the top level and the port checker

package kfs_pkg;

    // default sizes handed to the top level parameters
    localparam int MAX_ANIMS_DEF       = 32;
    localparam int TICKS_PER_FRAME_DEF = 4;

    // frame numbers wrap at this count before they are cut to eight bits
    localparam int MAX_FRAMES = 256;

    // field widths of the stream items
    localparam int ACT_W    = 2;
    localparam int IDX_W    = 5;
    localparam int FRAME_W  = 8;
    localparam int PHASE_W  = 2;
    localparam int COUNT_W  = 6;
    localparam int IN_W     = 24;
    localparam int OUT_W    = 24;

    // a table word holds the end frame above the start frame
    localparam int ENTRY_W = 2 * FRAME_W;

    // kind of an input item
    typedef enum logic [ACT_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_CHANGE = 2'd1,
        ACT_LOAD   = 2'd2
    } t_action;

endpackage

[rtl/core/keyframe_animation_sequencer_unit.sv]
// keyframe_animation_sequencer_unit: top level of the keyframe animation sequencer
// depends on kfs_pkg and kfs_ram (start/end frame table)
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid/s_axis_tready    tuser: action; tdata: index, one-shot, frames
//  m_axis    out  m_axis_tvalid/m_axis_tready    tdata: frames, phase, animation, one-shot
//  cfg       in   i_cfg_we                       i_cfg_wdata: anim_count
//
// one item per cycle sustained while m_axis is not stalled; each item passes two
// steps to its result: the table read, then the state update into the output register.
// the table ram read is issued with the state the previous item leaves, so
// back-to-back items never wait on each other.
// a stalled m_axis holds the output register and stops s_axis one item later.
// synchronous active-low reset; the table reads as zero until an entry is loaded.

module keyframe_animation_sequencer_unit #(
    parameter int MAX_ANIMS       = kfs_pkg::MAX_ANIMS_DEF,
    parameter int TICKS_PER_FRAME = kfs_pkg::TICKS_PER_FRAME_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // stream input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] action
    input  logic [kfs_pkg::ACT_W-1:0]     s_axis_tuser,
    // [4:0] anim_index, [5] oneshot_request, [13:6] frame_start, [21:14] frame_end
    input  logic [kfs_pkg::IN_W-1:0]      s_axis_tdata,
    // stream output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] current_frame, [15:8] next_frame, [17:16] interp_phase,
    // [22:18] active_anim, [23] oneshot_active
    output logic [kfs_pkg::OUT_W-1:0]     m_axis_tdata,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [kfs_pkg::COUNT_W-1:0]   i_cfg_wdata
);

    localparam int AW = (MAX_ANIMS > 1) ? $clog2(MAX_ANIMS) : 1;
    localparam int TD = 1 << AW;
    localparam int PW = (TICKS_PER_FRAME > 1) ? $clog2(TICKS_PER_FRAME) : 1;

    localparam int FW = kfs_pkg::FRAME_W;
    localparam int IW = kfs_pkg::IDX_W;

    // input item fields
    kfs_pkg::t_action  w_in_act;
    logic [IW-1:0]     w_in_idx;
    logic              w_in_once;
    logic [FW-1:0]     w_in_fs;
    logic [FW-1:0]     w_in_fe;
    logic              w_in_fire;

    // execute stage
    logic              r_e_valid;
    kfs_pkg::t_action  r_e_act;
    logic [IW-1:0]     r_e_idx;
    logic              r_e_once;
    logic              w_e_fire;

    // sequencer state
    logic [kfs_pkg::COUNT_W-1:0] r_anim_count;
    logic [IW-1:0]     r_play,  n_play;
    logic [IW-1:0]     r_ret,   n_ret;
    logic              r_flag,  n_flag;
    logic [PW-1:0]     r_phase, n_phase;
    logic [FW-1:0]     r_shown, n_shown;
    logic [FW-1:0]     r_up,    n_up;

    // table ram and its valid bits
    logic [TD-1:0]     r_tbl_vld;
    logic              w_tbl_we;
    logic [AW-1:0]     w_tbl_waddr;
    logic [AW-1:0]     w_rd_addr_a;
    logic [AW-1:0]     w_rd_addr_b;
    logic [kfs_pkg::ENTRY_W-1:0] w_rd_a;
    logic [kfs_pkg::ENTRY_W-1:0] w_rd_b;
    logic              r_ok_a;
    logic              r_ok_b;
    logic [FW-1:0]     w_start_a;
    logic [FW-1:0]     w_end_a;
    logic [FW-1:0]     w_start_b;

    // execute helpers
    logic [IW-1:0]     w_tick_ret;
    logic [PW:0]       w_phase_inc;
    logic              w_chg_ok;

    // output register
    logic              r_o_valid;
    logic [kfs_pkg::OUT_W-1:0] r_o_data;

    // unpack the input item
    assign w_in_act  = kfs_pkg::t_action'(s_axis_tuser);
    assign w_in_idx  = s_axis_tdata[4:0];
    assign w_in_once = s_axis_tdata[5];
    assign w_in_fs   = s_axis_tdata[13:6];
    assign w_in_fe   = s_axis_tdata[21:14];

    // handshake chain: execute moves when the output register frees up
    assign w_e_fire      = r_e_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !r_e_valid || w_e_fire;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // table write happens on acceptance of a load item whose index is below MAX_ANIMS
    assign w_tbl_we    = w_in_fire && (w_in_act == kfs_pkg::ACT_LOAD)
                         && (int'(w_in_idx) < MAX_ANIMS);
    assign w_tbl_waddr = AW'(w_in_idx);

    // read addresses follow the state left by the executing item; b reads a change item's index
    assign w_rd_addr_a = AW'(n_play);
    assign w_rd_addr_b = (w_in_act == kfs_pkg::ACT_CHANGE) ? AW'(w_in_idx) : AW'(n_ret);

    kfs_ram #(
        .WIDTH (kfs_pkg::ENTRY_W),
        .DEPTH (MAX_ANIMS)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_we      (w_tbl_we),
        .i_waddr   (w_tbl_waddr),
        .i_wdata   ({w_in_fe, w_in_fs}),
        .i_re      (w_in_fire),
        .i_raddr_a (w_rd_addr_a),
        .i_raddr_b (w_rd_addr_b),
        .o_rdata_a (w_rd_a),
        .o_rdata_b (w_rd_b)
    );

    // valid bits: an entry never loaded reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
        end else if (w_tbl_we) begin
            r_tbl_vld[w_tbl_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_ok_a <= r_tbl_vld[w_rd_addr_a];
            r_ok_b <= r_tbl_vld[w_rd_addr_b];
        end
    end

    assign w_start_a = r_ok_a ? w_rd_a[FW-1:0]  : '0;
    assign w_end_a   = r_ok_a ? w_rd_a[2*FW-1:FW] : '0;
    assign w_start_b = r_ok_b ? w_rd_b[FW-1:0]  : '0;

    // execute stage item registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_e_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_e_act  <= w_in_act;
            r_e_idx  <= w_in_idx;
            r_e_once <= w_in_once;
        end
    end

    // animation count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_anim_count <= '0;
        end else if (i_cfg_we) begin
            r_anim_count <= i_cfg_wdata;
        end
    end

    // helpers for tick and change
    assign w_tick_ret  = r_flag ? r_ret : r_play;
    assign w_phase_inc = (PW + 1)'(r_phase) + (PW + 1)'(1);
    assign w_chg_ok    = (r_e_idx != r_play)
                         && ((kfs_pkg::COUNT_W)'(r_e_idx) < r_anim_count)
                         && (int'(r_e_idx) < MAX_ANIMS);

    // state update of the executing item
    always_comb begin
        n_play  = r_play;
        n_ret   = r_ret;
        n_flag  = r_flag;
        n_phase = r_phase;
        n_shown = r_shown;
        n_up    = r_up;
        if (w_e_fire) begin
            unique case (r_e_act)
                kfs_pkg::ACT_TICK: begin
                    n_ret = w_tick_ret;
                    if (w_phase_inc == (PW + 1)'(TICKS_PER_FRAME)) begin
                        n_phase = '0;
                        n_shown = r_up;
                        if (r_up >= w_end_a) begin
                            if (r_flag) begin
                                // one-shot done: hand back to the interrupted animation
                                n_play = w_tick_ret;
                                n_ret  = r_play;
                                n_flag = 1'b0;
                                n_up   = w_start_b;
                            end else begin
                                n_up   = w_start_a;
                            end
                        end else begin
                            n_up = FW'((9'(r_up) + 9'd1) % kfs_pkg::MAX_FRAMES);
                        end
                    end else begin
                        n_phase = PW'(w_phase_inc);
                    end
                end
                kfs_pkg::ACT_CHANGE: begin
                    if (w_chg_ok) begin
                        if (!r_e_once && r_flag) begin
                            // deferred until the one-shot ends
                            n_ret = r_e_idx;
                        end else begin
                            n_flag = r_e_once;
                            n_ret  = r_play;
                            n_play = r_e_idx;
                            n_up   = w_start_b;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play  <= '0;
            r_ret   <= '0;
            r_flag  <= 1'b0;
            r_phase <= '0;
            r_shown <= '0;
            r_up    <= '0;
        end else begin
            r_play  <= n_play;
            r_ret   <= n_ret;
            r_flag  <= n_flag;
            r_phase <= n_phase;
            r_shown <= n_shown;
            r_up    <= n_up;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_e_fire) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_e_fire) begin
            r_o_data <= {n_flag, n_play, (kfs_pkg::PHASE_W)'(n_phase), n_up, n_shown};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_data;

endmodule

[rtl/core/kfs_ram.sv]
// kfs_ram: generic synchronous ram, one write port and two read ports
// registered read data with a shared read enable; no dependencies

module kfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_a,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

[rtl/core/kfs_checker.sv]
// kfs_checker: port-level assertions for the keyframe animation sequencer
// depends on kfs_pkg; bound to keyframe_animation_sequencer_unit below

module kfs_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [kfs_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [1:0] r_pending;
    logic       w_in_fire;
    logic       w_out_fire;

    assign w_in_fire  = s_axis_tvalid && s_axis_tready;
    assign w_out_fire = m_axis_tvalid && m_axis_tready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + 2'(w_in_fire) - 2'(w_out_fire);
        end
    end

    // at most two items in flight: execute stage and output register
    a_pending_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("more items in flight than stages");

    // no result without an item behind it
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_pending != 2'd0))
        else $error("result with no pending item");

    // an empty block always takes an item
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pending == 2'd0) |-> s_axis_tready)
        else $error("empty block not ready");

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind keyframe_animation_sequencer_unit kfs_checker u_kfs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
